// ----- design/ffx_pkg.sv -----
// Shared types, character codes and reset constants for the form field extractor.
// Used by every module of the block; depends on nothing.
package ffx_pkg;

    localparam int MAX_NAME_BYTES = 8;
    localparam int QUEUE_DEPTH    = 4;

    localparam int NAME_W  = 64;
    localparam int LEN_W   = 4;
    localparam int LIMIT_W = 20;

    // Character codes
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Register reset values
    localparam logic [NAME_W-1:0]  NAME_RESET  = 64'd1752457584;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 4'd4;
    localparam logic               PLUS_RESET  = 1'b1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd511;

    typedef enum logic [1:0] {
        CFG_FIELD_NAME    = 2'd0,
        CFG_NAME_LENGTH   = 2'd1,
        CFG_PLUS_TO_SPACE = 2'd2,
        CFG_VALUE_LIMIT   = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_KEY   = 2'd0,
        PH_SKIP  = 2'd1,
        PH_VALUE = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_BADHEX   = 2'd2,
        ST_TOOLONG  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       done_res;
        logic [1:0] status;
    } t_out_item;

    // Classified request as it waits between front and back
    typedef struct packed {
        logic [7:0] body_byte;
        logic       last_byte;
        logic       is_amp;
        logic       is_eq;
        logic       is_pct;
        logic       is_plus;
        logic       hex_ok;
        logic [3:0] hex_val;
    } t_class;

    typedef struct packed {
        logic [LEN_W-1:0]   key_length;
        logic               plus_to_space;
        logic [LIMIT_W-1:0] value_limit;
    } t_cfg;

endpackage

// ----- design/ffx_front.sv -----
// Front end: accepts body bytes and classifies them (separators, escapes, hex digits).
// Uses ffx_pkg types; feeds ffx_queue.
module ffx_front (
    input  logic             i_in_valid,
    input  ffx_pkg::t_in_item i_in,
    output logic             o_in_stall,
    input  logic             i_q_full,
    output logic             o_push,
    output ffx_pkg::t_class  o_push_item
);

    logic       is_dec;
    logic       is_lo;
    logic       is_up;
    logic [7:0] digit;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        is_dec = (i_in.body_byte >= ffx_pkg::CH_0)    && (i_in.body_byte <= ffx_pkg::CH_9);
        is_lo  = (i_in.body_byte >= ffx_pkg::CH_A_LO) && (i_in.body_byte <= ffx_pkg::CH_F_LO);
        is_up  = (i_in.body_byte >= ffx_pkg::CH_A_UP) && (i_in.body_byte <= ffx_pkg::CH_F_UP);
        if (is_lo) begin
            digit = i_in.body_byte - ffx_pkg::CH_A_LO + 8'd10;
        end else if (is_up) begin
            digit = i_in.body_byte - ffx_pkg::CH_A_UP + 8'd10;
        end else begin
            digit = i_in.body_byte - ffx_pkg::CH_0;
        end

        o_push_item.body_byte = i_in.body_byte;
        o_push_item.last_byte = i_in.last_byte;
        o_push_item.is_amp    = (i_in.body_byte == ffx_pkg::CH_AMP);
        o_push_item.is_eq     = (i_in.body_byte == ffx_pkg::CH_EQ);
        o_push_item.is_pct    = (i_in.body_byte == ffx_pkg::CH_PCT);
        o_push_item.is_plus   = (i_in.body_byte == ffx_pkg::CH_PLUS);
        o_push_item.hex_ok    = is_dec || is_lo || is_up;
        o_push_item.hex_val   = digit[3:0];
    end

endmodule

// ----- design/ffx_queue.sv -----
// Short request queue between the classifying front and the decoding back.
// Uses ffx_pkg::t_class; depth comes from the top level.
module ffx_queue #(
    parameter int DEPTH = ffx_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ffx_pkg::t_class i_push_item,
    output logic            o_full,
    output logic            o_head_valid,
    output ffx_pkg::t_class o_head_item,
    input  logic            i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ffx_pkg::t_class  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_pop;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head_item  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ----- design/ffx_back.sv -----
// Back end: key matching, percent decoding and status generation, one request per commit.
// Uses ffx_pkg types; drains ffx_queue and owns the output register and its hold stage.
module ffx_back #(
    parameter int MAX_NAME_BYTES = ffx_pkg::MAX_NAME_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffx_pkg::t_cfg                 i_cfg,
    input  logic [8*MAX_NAME_BYTES-1:0]   i_field_name,
    input  logic                          i_q_valid,
    input  ffx_pkg::t_class               i_q_item,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    output ffx_pkg::t_out_item            o_out,
    input  logic                          i_out_stall
);

    localparam int IDX_W = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
    localparam logic [ffx_pkg::LEN_W-1:0] MAX_LEN = ffx_pkg::LEN_W'(MAX_NAME_BYTES);

    // State
    ffx_pkg::t_phase    r_phase, n_phase;
    logic [3:0]         r_kpos,  n_kpos;
    logic               r_kmis,  n_kmis;
    logic [1:0]         r_pcnt,  n_pcnt;
    logic [7:0]         r_pch,   n_pch;
    logic               r_pch_plus,   n_pch_plus;
    logic               r_pch_hex_ok, n_pch_hex_ok;
    logic [3:0]         r_pch_hex,    n_pch_hex;
    logic [19:0]        r_dcnt,  n_dcnt;
    logic               r_out_v,  n_out_v;
    ffx_pkg::t_out_item r_out,    n_out;
    logic               r_hold_v, n_hold_v;
    ffx_pkg::t_out_item r_hold,   n_hold;

    // Plan for the head request
    logic [MAX_NAME_BYTES-1:0][7:0] name_bytes;
    logic [3:0]         klen;
    logic [7:0]         want;
    logic               key_match;
    logic [7:0]         plain_b;
    logic [7:0]         plain_pch;
    ffx_pkg::t_phase    go_phase;
    logic [1:0]         nb;
    logic [7:0]         b0, b1;
    logic               fin_req;
    ffx_pkg::t_status   fin_st;
    logic [3:0]         p_kpos;
    logic               p_kmis;
    logic [1:0]         p_pcnt;
    logic [7:0]         p_pch;
    logic               p_pch_plus;
    logic               p_pch_hex_ok;
    logic [3:0]         p_pch_hex;
    logic [19:0]        dcnt_base;

    // Emission
    logic [19:0]        c1, c2;
    logic               tl1, tl2;
    logic [1:0]         emitted;
    logic               fin;
    ffx_pkg::t_status   st_out;
    logic [1:0]         nres;
    ffx_pkg::t_out_item res0, res1;
    logic               out_free;
    logic               commit;
    logic               clear_body;

    assign name_bytes = i_field_name;
    assign klen       = (i_cfg.key_length > MAX_LEN) ? MAX_LEN : i_cfg.key_length;
    assign want       = name_bytes[r_kpos[IDX_W-1:0]];
    assign key_match  = !r_kmis && (r_kpos == klen);
    assign plain_b    = (i_q_item.is_plus && i_cfg.plus_to_space) ? ffx_pkg::CH_SPACE
                                                                  : i_q_item.body_byte;
    assign plain_pch  = (r_pch_plus && i_cfg.plus_to_space) ? ffx_pkg::CH_SPACE : r_pch;

    always_comb begin
        go_phase     = r_phase;
        nb           = 2'd0;
        b0           = ffx_pkg::CH_PCT;
        b1           = plain_pch;
        fin_req      = 1'b0;
        fin_st       = ffx_pkg::ST_OK;
        p_kpos       = r_kpos;
        p_kmis       = r_kmis;
        p_pcnt       = r_pcnt;
        p_pch        = r_pch;
        p_pch_plus   = r_pch_plus;
        p_pch_hex_ok = r_pch_hex_ok;
        p_pch_hex    = r_pch_hex;
        dcnt_base    = r_dcnt;
        case (r_phase)
            ffx_pkg::PH_KEY: begin
                if (i_q_item.is_amp) begin
                    fin_req = 1'b1;
                    fin_st  = ffx_pkg::ST_NOTFOUND;
                end else if (i_q_item.is_eq) begin
                    if (key_match) begin
                        go_phase  = ffx_pkg::PH_VALUE;
                        dcnt_base = '0;
                        p_pcnt    = 2'd0;
                        fin_req   = i_q_item.last_byte;
                        fin_st    = ffx_pkg::ST_OK;
                    end else begin
                        go_phase = ffx_pkg::PH_SKIP;
                        fin_req  = i_q_item.last_byte;
                        fin_st   = ffx_pkg::ST_NOTFOUND;
                    end
                end else begin
                    if (r_kpos < klen) begin
                        if (want != i_q_item.body_byte) begin
                            p_kmis = 1'b1;
                        end
                        p_kpos = r_kpos + 4'd1;
                    end else begin
                        p_kmis = 1'b1;
                    end
                    fin_req = i_q_item.last_byte;
                    fin_st  = ffx_pkg::ST_NOTFOUND;
                end
            end
            ffx_pkg::PH_SKIP: begin
                if (i_q_item.last_byte) begin
                    fin_req = 1'b1;
                    fin_st  = ffx_pkg::ST_NOTFOUND;
                end else if (i_q_item.is_amp) begin
                    go_phase = ffx_pkg::PH_KEY;
                    p_kpos   = 4'd0;
                    p_kmis   = 1'b0;
                end
            end
            ffx_pkg::PH_VALUE: begin
                if (i_q_item.is_amp) begin
                    // flush a dangling escape literally, then close ok
                    nb      = r_pcnt;
                    fin_req = 1'b1;
                    p_pcnt  = 2'd0;
                end else if (r_pcnt == 2'd0) begin
                    if (r_dcnt >= i_cfg.value_limit) begin
                        fin_req = 1'b1;
                        fin_st  = ffx_pkg::ST_TOOLONG;
                    end else if (i_q_item.is_pct) begin
                        p_pcnt = 2'd1;
                        if (i_q_item.last_byte) begin
                            nb      = 2'd1;
                            fin_req = 1'b1;
                            p_pcnt  = 2'd0;
                        end
                    end else begin
                        nb      = 2'd1;
                        b0      = plain_b;
                        fin_req = i_q_item.last_byte;
                    end
                end else if (r_pcnt == 2'd1) begin
                    p_pcnt       = 2'd2;
                    p_pch        = i_q_item.body_byte;
                    p_pch_plus   = i_q_item.is_plus;
                    p_pch_hex_ok = i_q_item.hex_ok;
                    p_pch_hex    = i_q_item.hex_val;
                    if (i_q_item.last_byte) begin
                        nb      = 2'd2;
                        b1      = plain_b;
                        fin_req = 1'b1;
                        p_pcnt  = 2'd0;
                    end
                end else begin
                    p_pcnt = 2'd0;
                    if (!(r_pch_hex_ok && i_q_item.hex_ok)) begin
                        fin_req = 1'b1;
                        fin_st  = ffx_pkg::ST_BADHEX;
                    end else begin
                        nb      = 2'd1;
                        b0      = {r_pch_hex, i_q_item.hex_val};
                        fin_req = i_q_item.last_byte;
                    end
                end
            end
            default: begin
                // finished body: ignore until the last byte
            end
        endcase
    end

    // Each emitted byte bumps the count; reaching the limit cuts the list and ends the body
    always_comb begin
        c1      = dcnt_base + 20'd1;
        c2      = dcnt_base + 20'd2;
        tl1     = (nb != 2'd0) && (c1 >= i_cfg.value_limit);
        tl2     = (nb == 2'd2) && !tl1 && (c2 >= i_cfg.value_limit);
        emitted = tl1 ? 2'd1 : nb;
        fin     = tl1 || tl2 || fin_req;
        st_out  = (tl1 || tl2) ? ffx_pkg::ST_TOOLONG : fin_st;
        if (emitted != 2'd0) begin
            nres = emitted;
        end else begin
            nres = fin ? 2'd1 : 2'd0;
        end

        if (emitted != 2'd0) begin
            res0.out_byte = b0;
            res0.has_byte = 1'b1;
            res0.done_res = fin && (emitted == 2'd1);
            res0.status   = (fin && (emitted == 2'd1)) ? st_out : ffx_pkg::ST_OK;
        end else begin
            res0.out_byte = 8'd0;
            res0.has_byte = 1'b0;
            res0.done_res = 1'b1;
            res0.status   = st_out;
        end
        res1.out_byte = b1;
        res1.has_byte = 1'b1;
        res1.done_res = fin;
        res1.status   = fin ? st_out : ffx_pkg::ST_OK;
    end

    assign out_free   = !r_out_v || !i_out_stall;
    assign commit     = i_q_valid && ((nres == 2'd0) || (!r_hold_v && out_free));
    assign o_q_pop    = commit;
    assign clear_body = i_q_item.last_byte && (fin || (r_phase == ffx_pkg::PH_DONE));

    // Next phase
    always_comb begin
        if (clear_body) begin
            n_phase = ffx_pkg::PH_KEY;
        end else if (fin || (r_phase == ffx_pkg::PH_DONE)) begin
            n_phase = ffx_pkg::PH_DONE;
        end else begin
            n_phase = go_phase;
        end
    end

    // Next per-body state
    always_comb begin
        if (clear_body) begin
            n_kpos = 4'd0;
            n_kmis = 1'b0;
            n_pcnt = 2'd0;
            n_dcnt = '0;
        end else begin
            n_kpos = p_kpos;
            n_kmis = p_kmis;
            n_pcnt = p_pcnt;
            n_dcnt = dcnt_base + {18'd0, emitted};
        end
        n_pch        = p_pch;
        n_pch_plus   = p_pch_plus;
        n_pch_hex_ok = p_pch_hex_ok;
        n_pch_hex    = p_pch_hex;
    end

    // Output register and hold stage for the second result of a request
    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        if (out_free) begin
            if (r_hold_v) begin
                n_out    = r_hold;
                n_out_v  = 1'b1;
                n_hold_v = 1'b0;
            end else if (commit && (nres != 2'd0)) begin
                n_out    = res0;
                n_out_v  = 1'b1;
                n_hold_v = (nres == 2'd2);
                n_hold   = res1;
            end else begin
                n_out_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ffx_pkg::PH_KEY;
            r_kpos   <= 4'd0;
            r_kmis   <= 1'b0;
            r_pcnt   <= 2'd0;
            r_dcnt   <= '0;
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            if (commit) begin
                r_phase <= n_phase;
                r_kpos  <= n_kpos;
                r_kmis  <= n_kmis;
                r_pcnt  <= n_pcnt;
                r_dcnt  <= n_dcnt;
            end
            r_out_v  <= n_out_v;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_pch        <= n_pch;
            r_pch_plus   <= n_pch_plus;
            r_pch_hex_ok <= n_pch_hex_ok;
            r_pch_hex    <= n_pch_hex;
        end
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> r_out_v)
        else $error("hold stage full while output register empty");

    a_no_escape_outside_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ffx_pkg::PH_KEY || r_phase == ffx_pkg::PH_SKIP) |-> (r_pcnt == 2'd0))
        else $error("pending escape outside a value");

    a_escape_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt != 2'd3)
        else $error("pending escape count out of range");

    a_done_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && fin && !i_q_item.last_byte) |=> (r_phase == ffx_pkg::PH_DONE))
        else $error("body not closed after its final result");

    a_second_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && nres == 2'd2) |=> r_hold_v)
        else $error("second result of a request lost");

endmodule

// ----- design/form_field_extractor_core.sv -----
// Top level of the form field extractor: configuration registers and the front/queue/back chain.
// Depends on ffx_pkg, ffx_front, ffx_queue and ffx_back.
//
// Feed the url-encoded form body one byte per request on the input channel, with last_byte set
// on the final byte. The block looks for the first key=value pair whose key equals field_name
// (field_name_length characters, first character in the lowest byte) and streams out the
// percent-decoded value one byte per result, then a closing result with done_res set and the
// status: ok, key not found, bad hex digit after '%', or value too long (decoded count reached
// value_limit). When the last value byte and the end coincide they share one result. Bytes
// after the closing result produce nothing; the byte carrying last_byte rearms the block for
// the next body. Throughput is one input byte per clock until the queue is full: the front
// classifies each byte on acceptance and pushes it into a QUEUE_DEPTH-entry queue; the back
// commits one queued request per clock unless the output is busy. A two-result request (a
// dangling "%x" flushed at the end of a value) holds the back until its second result leaves
// the one-entry hold stage; the output register drains one result per clock when not stalled.
// Results pass a queue entry and the output register, which drives the output valid. The input
// stall rises only when the queue is full. Write the configuration only while no body is in
// flight; the configuration channel is always ready and writes take effect on the next request.
module form_field_extractor_core #(
    parameter int MAX_NAME_BYTES = ffx_pkg::MAX_NAME_BYTES,
    parameter int QUEUE_DEPTH    = ffx_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // body byte channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ffx_pkg::t_in_item          i_in,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ffx_pkg::t_out_item         o_out,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [ffx_pkg::NAME_W-1:0] i_cfg_data
);

    localparam int NAME_BITS = 8 * MAX_NAME_BYTES;

    // Configuration registers; only the key bytes the back can compare are kept
    logic [NAME_BITS-1:0] r_field_name;
    ffx_pkg::t_cfg        r_cfg;

    logic                 q_full;
    logic                 q_push;
    ffx_pkg::t_class      q_push_item;
    logic                 q_head_valid;
    ffx_pkg::t_class      q_head_item;
    logic                 q_pop;

    // Always ready: each accepted write goes straight into its register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_name        <= ffx_pkg::NAME_RESET[NAME_BITS-1:0];
            r_cfg.key_length    <= ffx_pkg::LEN_RESET;
            r_cfg.plus_to_space <= ffx_pkg::PLUS_RESET;
            r_cfg.value_limit   <= ffx_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ffx_pkg::t_cfg_reg'(i_cfg_index))
                ffx_pkg::CFG_FIELD_NAME: begin
                    r_field_name <= i_cfg_data[NAME_BITS-1:0];
                end
                ffx_pkg::CFG_NAME_LENGTH: begin
                    r_cfg.key_length <= i_cfg_data[ffx_pkg::LEN_W-1:0];
                end
                ffx_pkg::CFG_PLUS_TO_SPACE: begin
                    r_cfg.plus_to_space <= i_cfg_data[0];
                end
                ffx_pkg::CFG_VALUE_LIMIT: begin
                    r_cfg.value_limit <= i_cfg_data[ffx_pkg::LIMIT_W-1:0];
                end
                default: begin
                    // no register at this index: drop the write
                end
            endcase
        end
    end

    // Classify each accepted byte on its way into the queue
    ffx_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_item (q_push_item)
    );

    // Decouple acceptance from decoding so each side stalls on its own
    ffx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_item  (q_push_item),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head_item  (q_head_item),
        .i_pop        (q_pop)
    );

    // Match the key, decode the value and produce results
    ffx_back #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_field_name (r_field_name),
        .i_q_valid    (q_head_valid),
        .i_q_item     (q_head_item),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out),
        .i_out_stall  (i_out_stall)
    );

endmodule

// ----- test/form_field_extractor_core_tb.sv -----
// Self-checking testbench for form_field_extractor_core: form body bytes in, decoded value out.
// Depends on ffx_pkg and the design; an in-bench decoder works out every result it must emit.
module form_field_extractor_core_tb;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    // A request that makes no result may still sit in the queue or the back stage
    // when the last result has arrived; allow for queue depth plus pipeline.
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 120;
    localparam int RANDOM_PHASES = 8;
    localparam int RANDOM_BYTES  = 1850;
    localparam int CYCLE_LIMIT   = 500000;

    // Shapes of a key put into a random body
    localparam int KEY_EXACT    = 0;
    localparam int KEY_PREFIX   = 1;
    localparam int KEY_MUTATED  = 2;
    localparam int KEY_EXTENDED = 3;
    localparam int KEY_RANDOM   = 4;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    ffx_pkg::t_in_item          in_item;
    logic                       out_valid;
    logic                       out_stall;
    ffx_pkg::t_out_item         out_item;
    logic                       cfg_valid;
    logic                       cfg_ready;
    ffx_pkg::t_cfg_reg          cfg_index;
    logic [ffx_pkg::NAME_W-1:0] cfg_data;

    // Stimulus controls shared between the sender, the receiver and the tests
    bit sender_idling    = 1'b1;
    bit receiver_idling  = 1'b1;
    bit hold_off_request = 1'b0;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Bytes of the body being built, sent in order with last_byte on the final one
    logic [7:0] body_buf[$];

    // Decoded results still to arrive, oldest first
    ffx_pkg::t_out_item decoded_results[$];
    ffx_pkg::t_out_item result_seen;
    ffx_pkg::t_out_item result_due;

    // In-bench decoder: configuration copy
    logic [ffx_pkg::NAME_W-1:0]  key_name;
    logic [ffx_pkg::LEN_W-1:0]   key_len;
    logic                        plus_sp;
    logic [ffx_pkg::LIMIT_W-1:0] lim;

    // In-bench decoder: per-body state
    ffx_pkg::t_phase             ph;
    logic [3:0]                  kpos;
    logic                        kmis;
    logic [1:0]                  pcnt;
    logic [15:0]                 pchars;
    logic [ffx_pkg::LIMIT_W-1:0] dcnt;

    // Results of the request being decoded; at most two, one spare
    ffx_pkg::t_out_item step_out [0:2];
    int                 step_n;
    bit                 step_final;

    form_field_extractor_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Guard against a hang: end the run if it overruns the cycle budget
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // In-bench decoder
    // ------------------------------------------------------------------

    task automatic clear_body();
        ph     = ffx_pkg::PH_KEY;
        kpos   = '0;
        kmis   = 1'b0;
        pcnt   = '0;
        pchars = '0;
        dcnt   = '0;
    endtask

    task automatic reset_decoder();
        key_name = ffx_pkg::NAME_RESET;
        key_len  = ffx_pkg::LEN_RESET;
        plus_sp  = ffx_pkg::PLUS_RESET;
        lim      = ffx_pkg::LIMIT_RESET;
        clear_body();
    endtask

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = '0;
        if (c >= ffx_pkg::CH_0 && c <= ffx_pkg::CH_9) begin
            d = c - ffx_pkg::CH_0;
            return {1'b1, d[3:0]};
        end
        if (c >= ffx_pkg::CH_A_LO && c <= ffx_pkg::CH_F_LO) begin
            d = c - ffx_pkg::CH_A_LO + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= ffx_pkg::CH_A_UP && c <= ffx_pkg::CH_F_UP) begin
            d = c - ffx_pkg::CH_A_UP + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'b0;
    endfunction

    function automatic logic [7:0] plain_char(input logic [7:0] c);
        return (c == ffx_pkg::CH_PLUS && plus_sp) ? ffx_pkg::CH_SPACE : c;
    endfunction

    // Close the body with a status; fold it into a byte result of this request if there is one
    task automatic close_body(input ffx_pkg::t_status st, input logic last);
        ffx_pkg::t_out_item r;
        if (!step_final) begin
            if (step_n > 0 && !step_out[step_n - 1].done_res) begin
                step_out[step_n - 1].done_res = 1'b1;
                step_out[step_n - 1].status   = st;
            end else begin
                r          = '0;
                r.done_res = 1'b1;
                r.status   = st;
                step_out[step_n] = r;
                step_n++;
            end
            step_final = 1'b1;
        end
        if (last)
            clear_body();
        else
            ph = ffx_pkg::PH_DONE;
    endtask

    // Emit one decoded byte and stop the body once the count reaches the limit
    task automatic emit_byte(input logic [7:0] b, input logic last);
        ffx_pkg::t_out_item r;
        if (step_final)
            return;
        r          = '0;
        r.out_byte = b;
        r.has_byte = 1'b1;
        step_out[step_n] = r;
        step_n++;
        dcnt = dcnt + 1'b1;
        if (dcnt >= lim)
            close_body(ffx_pkg::ST_TOOLONG, last);
    endtask

    // End of the value: a dangling '%' and the character after it pass literally
    task automatic end_of_value(input logic last);
        if (pcnt >= 2'd1)
            emit_byte(ffx_pkg::CH_PCT, last);
        if (pcnt >= 2'd2)
            emit_byte(plain_char(pchars[15:8]), last);
        pcnt   = '0;
        pchars = '0;
        close_body(ffx_pkg::ST_OK, last);
    endtask

    // Work out the results of one accepted body byte and queue them
    task automatic decode_body_byte(input ffx_pkg::t_in_item item);
        logic [7:0] b;
        logic       last;
        logic [3:0] klen;
        logic [4:0] hi;
        logic [4:0] lo;
        bit         stopped;
        int         i;
        b          = item.body_byte;
        last       = item.last_byte;
        klen       = (key_len > 4'(ffx_pkg::MAX_NAME_BYTES)) ? 4'(ffx_pkg::MAX_NAME_BYTES)
                                                              : key_len;
        step_n     = 0;
        step_final = 1'b0;
        stopped    = 1'b0;

        case (ph)
            ffx_pkg::PH_DONE: begin
                // drop everything until the body ends
                if (last)
                    clear_body();
            end
            ffx_pkg::PH_KEY: begin
                if (b == ffx_pkg::CH_AMP) begin
                    close_body(ffx_pkg::ST_NOTFOUND, last);
                end else if (b == ffx_pkg::CH_EQ) begin
                    if (!kmis && kpos == klen) begin
                        ph     = ffx_pkg::PH_VALUE;
                        dcnt   = '0;
                        pcnt   = '0;
                        pchars = '0;
                        if (last)
                            end_of_value(1'b1);
                    end else begin
                        ph = ffx_pkg::PH_SKIP;
                        if (last)
                            close_body(ffx_pkg::ST_NOTFOUND, 1'b1);
                    end
                end else begin
                    if (kpos < klen) begin
                        if (key_name[8 * kpos +: 8] != b)
                            kmis = 1'b1;
                        kpos = kpos + 1'b1;
                    end else begin
                        kmis = 1'b1;
                    end
                    if (last)
                        close_body(ffx_pkg::ST_NOTFOUND, 1'b1);
                end
            end
            ffx_pkg::PH_SKIP: begin
                if (last) begin
                    close_body(ffx_pkg::ST_NOTFOUND, 1'b1);
                end else if (b == ffx_pkg::CH_AMP) begin
                    ph   = ffx_pkg::PH_KEY;
                    kpos = '0;
                    kmis = 1'b0;
                end
            end
            default: begin
                if (b == ffx_pkg::CH_AMP) begin
                    end_of_value(last);
                end else begin
                    if (pcnt == 2'd0) begin
                        // the limit wins over anything that follows
                        if (dcnt >= lim) begin
                            close_body(ffx_pkg::ST_TOOLONG, last);
                            stopped = 1'b1;
                        end else if (b == ffx_pkg::CH_PCT) begin
                            pcnt   = 2'd1;
                            pchars = {8'h00, ffx_pkg::CH_PCT};
                        end else begin
                            emit_byte(plain_char(b), last);
                        end
                    end else if (pcnt == 2'd1) begin
                        pcnt         = 2'd2;
                        pchars[15:8] = b;
                    end else begin
                        hi     = hex_value(pchars[15:8]);
                        lo     = hex_value(b);
                        pcnt   = '0;
                        pchars = '0;
                        if (!hi[4] || !lo[4]) begin
                            close_body(ffx_pkg::ST_BADHEX, last);
                            stopped = 1'b1;
                        end else begin
                            emit_byte({hi[3:0], lo[3:0]}, last);
                        end
                    end
                    if (!stopped && last && !step_final)
                        end_of_value(1'b1);
                end
            end
        endcase

        for (i = 0; i < step_n; i++)
            decoded_results.push_back(step_out[i]);
    endtask

    // ------------------------------------------------------------------
    // Result checking: compare every accepted result with the oldest one due
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            result_seen = out_item;
            if (decoded_results.size() == 0) begin
                $error("result arrived with none outstanding: byte %h has %b done %b status %0d",
                       result_seen.out_byte, result_seen.has_byte, result_seen.done_res,
                       result_seen.status);
                error_count++;
            end else begin
                result_due = decoded_results.pop_front();
                if (result_seen.out_byte !== result_due.out_byte) begin
                    $error("out_byte: expected %h, got %h", result_due.out_byte,
                           result_seen.out_byte);
                    error_count++;
                end
                if (result_seen.has_byte !== result_due.has_byte) begin
                    $error("has_byte: expected %b, got %b", result_due.has_byte,
                           result_seen.has_byte);
                    error_count++;
                end
                if (result_seen.done_res !== result_due.done_res) begin
                    $error("done_res: expected %b, got %b", result_due.done_res,
                           result_seen.done_res);
                    error_count++;
                end
                if (result_seen.status !== result_due.status) begin
                    $error("status: expected %0d, got %0d", result_due.status,
                           result_seen.status);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall in random bursts, or hold off for a long stretch on request
    // ------------------------------------------------------------------

    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_request = 1'b0;
            end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one request and wait for its acceptance; leave valid high so that a
    // following request can go straight out on the next edge.
    task automatic send_byte(input ffx_pkg::t_in_item item);
        int unsigned gap;
        gap = (sender_idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        decode_body_byte(item);
    endtask

    task automatic send_body();
        ffx_pkg::t_in_item item;
        int                i;
        for (i = 0; i < body_buf.size(); i++) begin
            item.body_byte = body_buf[i];
            item.last_byte = (i == body_buf.size() - 1);
            send_byte(item);
        end
        body_buf.delete();
    endtask

    // Hold the input idle until every result has come, then let the pipeline empty
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (decoded_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register request; valid stays high for a following one
    task automatic write_register(input ffx_pkg::t_cfg_reg idx,
                                  input logic [ffx_pkg::NAME_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            ffx_pkg::CFG_FIELD_NAME:    key_name = data;
            ffx_pkg::CFG_NAME_LENGTH:   key_len  = data[ffx_pkg::LEN_W-1:0];
            ffx_pkg::CFG_PLUS_TO_SPACE: plus_sp  = data[0];
            default:                    lim      = data[ffx_pkg::LIMIT_W-1:0];
        endcase
    endtask

    // Write all four registers; unused upper data bits carry random noise
    task automatic set_config(input logic [ffx_pkg::NAME_W-1:0] name,
                              input logic [ffx_pkg::LEN_W-1:0] len,
                              input logic plus, input logic [ffx_pkg::LIMIT_W-1:0] limit);
        logic [ffx_pkg::NAME_W-1:0] data;
        write_register(ffx_pkg::CFG_FIELD_NAME, name);
        data                       = {$urandom, $urandom};
        data[ffx_pkg::LEN_W-1:0]   = len;
        write_register(ffx_pkg::CFG_NAME_LENGTH, data);
        data                       = {$urandom, $urandom};
        data[0]                    = plus;
        write_register(ffx_pkg::CFG_PLUS_TO_SPACE, data);
        data                       = {$urandom, $urandom};
        data[ffx_pkg::LIMIT_W-1:0] = limit;
        write_register(ffx_pkg::CFG_VALUE_LIMIT, data);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Body building
    // ------------------------------------------------------------------

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            body_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] random_letter();
        int unsigned n;
        n = $urandom_range(0, 35);
        return (n < 26) ? 8'(ffx_pkg::CH_A_LO + n) : 8'(ffx_pkg::CH_0 + n - 26);
    endfunction

    function automatic logic [7:0] random_hex_digit();
        int unsigned n;
        n = $urandom_range(0, 21);
        if (n < 10)
            return 8'(ffx_pkg::CH_0 + n);
        if (n < 16)
            return 8'(ffx_pkg::CH_A_LO + n - 10);
        return 8'(ffx_pkg::CH_A_UP + n - 16);
    endfunction

    // Mostly plain characters so that keys can be matched; now and then any byte
    function automatic logic [ffx_pkg::NAME_W-1:0] random_key();
        logic [ffx_pkg::NAME_W-1:0] k;
        int                         i;
        k = '0;
        for (i = 0; i < ffx_pkg::MAX_NAME_BYTES; i++)
            k[8 * i +: 8] = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                         : random_letter();
        return k;
    endfunction

    task automatic add_key(input int shape);
        int unsigned klen;
        int unsigned pos;
        int unsigned n;
        int          i;
        logic [7:0]  c;
        klen = (key_len > ffx_pkg::MAX_NAME_BYTES) ? ffx_pkg::MAX_NAME_BYTES : key_len;
        pos  = (klen > 0) ? $urandom_range(0, klen - 1) : 0;
        n    = (shape == KEY_PREFIX && klen > 0) ? klen - 1 : klen;
        if (shape == KEY_RANDOM) begin
            repeat ($urandom_range(0, 9)) body_buf.push_back(random_letter());
        end else begin
            for (i = 0; i < n; i++) begin
                c = key_name[8 * i +: 8];
                if (shape == KEY_MUTATED && i == pos)
                    c = random_letter();
                body_buf.push_back(c);
            end
            if (shape == KEY_EXTENDED || (shape == KEY_MUTATED && klen == 0))
                body_buf.push_back(random_letter());
        end
    endtask

    // Value text with plus signs, good and bad escapes, lone '%' and raw bytes
    task automatic add_value();
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        repeat (n) begin
            case ($urandom_range(0, 9))
                5: body_buf.push_back(ffx_pkg::CH_PLUS);
                6: begin
                    body_buf.push_back(ffx_pkg::CH_PCT);
                    body_buf.push_back(random_hex_digit());
                    body_buf.push_back(random_hex_digit());
                end
                7: begin
                    body_buf.push_back(ffx_pkg::CH_PCT);
                    body_buf.push_back(8'($urandom_range(0, 255)));
                    body_buf.push_back(random_letter());
                end
                8: body_buf.push_back(ffx_pkg::CH_PCT);
                9: body_buf.push_back(8'($urandom_range(0, 255)));
                default: body_buf.push_back(random_letter());
            endcase
        end
    endtask

    // Mostly well-formed bodies of key=value pairs, some noise, some cut short
    task automatic build_random_body();
        int unsigned npairs;
        int unsigned hit;
        int unsigned cut;
        int          p;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12)) body_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            npairs = $urandom_range(1, 4);
            hit    = $urandom_range(0, npairs);
            for (p = 0; p < npairs; p++) begin
                if (p > 0)
                    body_buf.push_back(ffx_pkg::CH_AMP);
                add_key((p == hit) ? KEY_EXACT : $urandom_range(KEY_PREFIX, KEY_RANDOM));
                if ($urandom_range(0, 9) != 0) begin
                    body_buf.push_back(ffx_pkg::CH_EQ);
                    add_value();
                end
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) body_buf.push_back(8'($urandom_range(0, 255)));
            if (body_buf.size() > 1 && $urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, body_buf.size() - 1);
                while (body_buf.size() > cut) void'(body_buf.pop_back());
            end
        end
        if (body_buf.size() == 0)
            body_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset key and settings straight after reset
    task automatic test_reset_defaults();
        add_key(KEY_EXACT);
        add_text("=x");
        send_body();
        wait_for_results();
    endtask

    // Plus to space, good escape, byte extremes, dangling "%x" flushed at the end
    // together with the closing result; then a skipped pair, a bad escape and
    // bytes after the close that must be dropped.
    task automatic test_decoding();
        set_config(64'h6B, 4'd1, 1'b1, 20'd8);   // key "k"
        add_text("k=+%4a");
        body_buf.push_back(8'hFF);
        body_buf.push_back(8'h00);
        add_text("%4");
        send_body();
        add_text("x=1&k=%zz&q");
        send_body();
        wait_for_results();
    endtask

    // Limit zero: a non-empty value is too long before the escape is judged,
    // an empty value is fine; a lone '&' is a miss.
    task automatic test_limits();
        set_config(64'h6B, 4'd1, 1'b0, 20'd0);
        add_text("k=%z");
        send_body();
        add_text("k=");
        send_body();
        add_text("&");
        send_body();
        wait_for_results();
    endtask

    // Empty key matches a pair that starts with '='; one byte reaches limit one
    // on the last byte, so byte, close and status share a result.
    task automatic test_empty_key();
        set_config(random_key(), 4'd0, 1'b1, 20'd1);
        add_text("=");
        body_buf.push_back(8'h00);
        send_body();
        wait_for_results();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the queue fills and the input stalls; then pause until all results are in.
    task automatic test_backpressure();
        set_config(random_key(), 4'd3, 1'b1, 20'd1000);
        sender_idling    = 1'b0;
        hold_off_request = 1'b1;
        add_key(KEY_EXACT);
        body_buf.push_back(ffx_pkg::CH_EQ);
        repeat (40) body_buf.push_back(random_letter());
        send_body();
        wait_for_results();
        sender_idling = 1'b1;
    endtask

    // Random bodies over several settings, the extremes among them; the last
    // phase runs with no idling on either side.
    task automatic test_random_bodies();
        int          phase_idx;
        int unsigned sent;
        logic [3:0]  len;
        for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
            wait_for_results();
            if (phase_idx == RANDOM_PHASES - 1) begin
                sender_idling   = 1'b0;
                receiver_idling = 1'b0;
            end
            case (phase_idx)
                0: set_config(random_key(), 4'd8, 1'b1, 20'hFFFFF);
                1: set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 20'd0);
                2: set_config(random_key(), 4'd15, 1'b1, 20'd1);
                3: set_config(64'h0, 4'($urandom_range(1, 3)), 1'b0, 20'($urandom_range(2, 6)));
                default: begin
                    len = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(1, 8));
                    set_config(random_key(), len, 1'($urandom_range(0, 1)),
                               ($urandom_range(0, 4) == 0) ? 20'($urandom)
                                                           : 20'($urandom_range(0, 24)));
                end
            endcase
            sent = 0;
            while (sent < RANDOM_BYTES / RANDOM_PHASES) begin
                build_random_body();
                sent += body_buf.size();
                send_body();
            end
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= ffx_pkg::CFG_FIELD_NAME;
        cfg_data  <= '0;
        reset_decoder();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_decoding();
        test_limits();
        test_empty_key();
        test_backpressure();
        test_random_bodies();

        wait_for_results();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ffx_pkg.sv
design/ffx_front.sv
design/ffx_queue.sv
design/ffx_back.sv
design/form_field_extractor_core.sv
test/form_field_extractor_core_tb.sv
